>>> src/tkar_pkg.sv
package tkar_pkg;

    // Field widths of one event.
    localparam int TYPE_W  = 16;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int STAMP_W = 64;
    localparam int DATA_W  = TYPE_W + CODE_W + VALUE_W + STAMP_W;

    // Configuration registers.
    localparam int KEY_W = 10;
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] CFG_PHYS_A = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PHYS_B = 2'd1;
    localparam logic [IDX_W-1:0] CFG_VIRT_A = 2'd2;
    localparam logic [IDX_W-1:0] CFG_VIRT_B = 2'd3;

    // Default key codes.
    localparam logic [KEY_W-1:0] KEY_Z   = 10'd44;
    localparam logic [KEY_W-1:0] KEY_X   = 10'd45;
    localparam logic [KEY_W-1:0] KEY_F13 = 10'd183;
    localparam logic [KEY_W-1:0] KEY_F14 = 10'd184;

    // Event types and codes.
    localparam logic [TYPE_W-1:0]  TYPE_SYN  = 16'd0;
    localparam logic [TYPE_W-1:0]  TYPE_KEY  = 16'd1;
    localparam logic [TYPE_W-1:0]  TYPE_MSC  = 16'd4;
    localparam logic [CODE_W-1:0]  CODE_SCAN = 16'd4;
    localparam logic [VALUE_W-1:0] VAL_RELEASE = 32'd0;
    localparam logic [VALUE_W-1:0] VAL_PRESS   = 32'd1;
    localparam logic [VALUE_W-1:0] VAL_REPEAT  = 32'd2;

    // Beat index within one input item (up to three results).
    localparam int BEAT_W = 2;
    localparam logic [BEAT_W-1:0] BEAT_RELEASE = 2'd0;
    localparam logic [BEAT_W-1:0] BEAT_SYNC    = 2'd1;

    typedef struct packed {
        logic [STAMP_W-1:0] ev_stamp;
        logic signed [VALUE_W-1:0] ev_value;
        logic [CODE_W-1:0]  ev_code;
        logic [TYPE_W-1:0]  ev_type;
    } t_event;

    // Effective key codes after the zero-register substitution.
    typedef struct packed {
        logic [KEY_W-1:0] phys_a;
        logic [KEY_W-1:0] phys_b;
        logic [KEY_W-1:0] virt_a;
        logic [KEY_W-1:0] virt_b;
    } t_keys;

    // One result beat as produced by the core.
    typedef struct packed {
        t_event ev;
        logic   click;
        logic   last;
        logic   drop;
    } t_beat;

endpackage

>>> src/tkar_cfg.sv
module tkar_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tkar_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [tkar_pkg::KEY_W-1:0]  i_cfg_wdata,
    output tkar_pkg::t_keys             o_keys
);

    logic [tkar_pkg::KEY_W-1:0] r_phys_a;
    logic [tkar_pkg::KEY_W-1:0] r_phys_b;
    logic [tkar_pkg::KEY_W-1:0] r_virt_a;
    logic [tkar_pkg::KEY_W-1:0] r_virt_b;
    logic [tkar_pkg::KEY_W-1:0] n_phys_a;
    logic [tkar_pkg::KEY_W-1:0] n_phys_b;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phys_a <= tkar_pkg::KEY_Z;
            r_phys_b <= tkar_pkg::KEY_X;
            r_virt_a <= tkar_pkg::KEY_F13;
            r_virt_b <= tkar_pkg::KEY_F14;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tkar_pkg::CFG_PHYS_A: r_phys_a <= i_cfg_wdata;
                tkar_pkg::CFG_PHYS_B: r_phys_b <= i_cfg_wdata;
                tkar_pkg::CFG_VIRT_A: r_virt_a <= i_cfg_wdata;
                tkar_pkg::CFG_VIRT_B: r_virt_b <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A zero register falls back to its default; a zero virtual key follows
    // the physical key.
    always_comb begin
        n_phys_a = (r_phys_a != '0) ? r_phys_a : tkar_pkg::KEY_Z;
        n_phys_b = (r_phys_b != '0) ? r_phys_b : tkar_pkg::KEY_X;
        o_keys.phys_a = n_phys_a;
        o_keys.phys_b = n_phys_b;
        o_keys.virt_a = (r_virt_a != '0) ? r_virt_a : n_phys_a;
        o_keys.virt_b = (r_virt_b != '0) ? r_virt_b : n_phys_b;
    end

endmodule

>>> src/tkar_core.sv
module tkar_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tkar_pkg::t_event            i_item,
    input  logic [tkar_pkg::BEAT_W-1:0] i_idx,
    input  tkar_pkg::t_keys             i_keys,
    input  logic                        i_retire,
    output tkar_pkg::t_beat             o_beat
);

    logic r_a_down;
    logic r_b_down;
    logic r_active_a;
    logic n_a_down;
    logic n_b_down;
    logic n_active_a;

    logic                         is_scan;
    logic                         hit_a;
    logic                         hit_b;
    logic                         is_phys;
    logic                         is_repeat;
    logic                         is_odd_value;
    logic                         press;
    logic [1:0]                   sum;
    logic                         is_lone;
    logic                         is_final;
    logic [tkar_pkg::KEY_W-1:0]   act_key;
    logic [tkar_pkg::KEY_W-1:0]   other_key;
    logic [tkar_pkg::KEY_W-1:0]   lone_key;
    logic [tkar_pkg::KEY_W-1:0]   oc;

    // Classify the event against the two physical keys.
    always_comb begin
        is_scan  = (i_item.ev_type == tkar_pkg::TYPE_MSC) &&
                   (i_item.ev_code == tkar_pkg::CODE_SCAN);
        hit_a    = (i_item.ev_code == {{(tkar_pkg::CODE_W-tkar_pkg::KEY_W){1'b0}},
                                       i_keys.phys_a});
        hit_b    = (i_item.ev_code == {{(tkar_pkg::CODE_W-tkar_pkg::KEY_W){1'b0}},
                                       i_keys.phys_b});
        is_phys  = (i_item.ev_type == tkar_pkg::TYPE_KEY) && (hit_a || hit_b);
        is_repeat    = (i_item.ev_value == tkar_pkg::VAL_REPEAT);
        is_odd_value = (i_item.ev_value[tkar_pkg::VALUE_W-1:1] != '0);
        press    = i_item.ev_value[0];

        // Key levels after this event; the first key wins on a double match.
        n_a_down = hit_a ? press : r_a_down;
        n_b_down = hit_a ? r_b_down : press;
        sum      = {1'b0, n_a_down} + {1'b0, n_b_down} + {1'b0, press};
        is_lone  = (sum == 2'd2);
        is_final = (sum == 2'd0);

        act_key   = r_active_a ? i_keys.virt_a : i_keys.virt_b;
        other_key = r_active_a ? i_keys.virt_b : i_keys.virt_a;
        lone_key  = hit_a ? i_keys.virt_a : i_keys.virt_b;

        if (is_lone) begin
            n_active_a = hit_a;
        end else if (is_final) begin
            n_active_a = 1'b0;
        end else begin
            n_active_a = !r_active_a;
        end
    end

    // Build the result beat selected by the beat index.
    always_comb begin
        o_beat.ev    = i_item;
        o_beat.click = 1'b0;
        o_beat.last  = 1'b1;
        o_beat.drop  = 1'b0;
        oc           = act_key;
        if (is_scan) begin
            o_beat.drop = 1'b1;
        end else if (!is_phys) begin
            // Pass-through event.
        end else if (is_repeat) begin
            o_beat.drop = 1'b1;
        end else if (is_odd_value) begin
            o_beat.click = (i_item.ev_code != '0);
        end else if (is_lone || is_final) begin
            oc = is_lone ? lone_key : act_key;
            o_beat.ev.ev_code = {{(tkar_pkg::CODE_W-tkar_pkg::KEY_W){1'b0}}, oc};
            o_beat.click      = (oc != '0);
        end else begin
            // Switch: release of the active key, a sync, then the other press.
            case (i_idx)
                tkar_pkg::BEAT_RELEASE: begin
                    o_beat.ev.ev_type  = tkar_pkg::TYPE_KEY;
                    o_beat.ev.ev_code  = {{(tkar_pkg::CODE_W-tkar_pkg::KEY_W){1'b0}},
                                          act_key};
                    o_beat.ev.ev_value = tkar_pkg::VAL_RELEASE;
                    o_beat.ev.ev_stamp = '0;
                    o_beat.last        = 1'b0;
                end
                tkar_pkg::BEAT_SYNC: begin
                    o_beat.ev.ev_type  = tkar_pkg::TYPE_SYN;
                    o_beat.ev.ev_code  = '0;
                    o_beat.ev.ev_value = tkar_pkg::VAL_RELEASE;
                    o_beat.ev.ev_stamp = '0;
                    o_beat.last        = 1'b0;
                end
                default: begin
                    oc = other_key;
                    o_beat.ev.ev_code  = {{(tkar_pkg::CODE_W-tkar_pkg::KEY_W){1'b0}}, oc};
                    o_beat.ev.ev_value = tkar_pkg::VAL_PRESS;
                    o_beat.click       = (oc != '0);
                end
            endcase
        end
    end

    // Key state changes only when a handled press or release retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_down   <= 1'b0;
            r_b_down   <= 1'b0;
            r_active_a <= 1'b0;
        end else if (i_retire && !is_scan && is_phys && !is_odd_value) begin
            r_a_down   <= n_a_down;
            r_b_down   <= n_b_down;
            r_active_a <= n_active_a;
        end
    end

endmodule

>>> src/two_key_alternating_remapper.sv
// An accepted item is registered in the input register, and its first result
// is then registered in the output register, where an output stall holds it.
// Throughput: one item per cycle when it gives one or no result and the output
// is not stalled; a key switch gives three results and holds the input register.
// Reset: synchronous, active low; clears both valid flags, the key levels, the
// active flag and restores the default key codes.
module two_key_alternating_remapper (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [tkar_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [tkar_pkg::KEY_W-1:0]   i_cfg_wdata,
    // Input events.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // ev_type[15:0], ev_code[31:16], ev_value[63:32], ev_stamp[127:64]
    input  logic [tkar_pkg::DATA_W-1:0]  s_axis_tdata,
    // Output events.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_type[15:0], out_code[31:16], out_value[63:32], out_stamp[127:64]
    output logic [tkar_pkg::DATA_W-1:0]  m_axis_tdata,
    // click[0]
    output logic                         m_axis_tuser,
    output logic                         m_axis_tlast
);

    logic                          r_in_valid;
    tkar_pkg::t_event              r_in;
    logic [tkar_pkg::BEAT_W-1:0]   r_idx;
    logic                          r_out_valid;
    tkar_pkg::t_event              r_out;
    logic                          r_out_click;
    logic                          r_out_last;

    tkar_pkg::t_keys               keys;
    tkar_pkg::t_beat               beat;
    logic                          out_space;
    logic                          load;
    logic                          retire;
    logic                          in_take;

    tkar_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_keys      (keys)
    );

    tkar_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_in),
        .i_idx    (r_idx),
        .i_keys   (keys),
        .i_retire (retire),
        .o_beat   (beat)
    );

    // Handshake control.
    always_comb begin
        out_space     = !r_out_valid || m_axis_tready;
        load          = r_in_valid && !beat.drop && out_space;
        retire        = r_in_valid && (beat.drop || (out_space && beat.last));
        s_axis_tready = !r_in_valid || retire;
        in_take       = s_axis_tvalid && s_axis_tready;
    end

    // Input register and beat counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (retire) begin
                r_in_valid <= 1'b0;
            end
            if (retire) begin
                r_idx <= '0;
            end else if (load) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= s_axis_tdata;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out       <= beat.ev;
            r_out_click <= beat.click;
            r_out_last  <= beat.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_click;
    assign m_axis_tlast  = r_out_last;

    // The beat counter never passes the third result of a switch.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 2'd3)
        else $error("beat index out of range");

    // A partly emitted item stays in the input register.
    a_idx_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> r_in_valid)
        else $error("beat index set without an item");

    // A newly accepted item always starts at its first result.
    a_new_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_idx == '0))
        else $error("new item does not start at first beat");

    // Injected release and sync beats never carry a click.
    a_click_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> !r_out_click)
        else $error("click on an injected beat");

endmodule

>>> verif/tb_two_key_alternating_remapper.sv
module tb_two_key_alternating_remapper;
    timeunit 1ns;
    timeprecision 1ps;

    import tkar_pkg::*;

    // One emitted event together with its sideband flags.
    typedef struct {
        t_event ev;
        logic   click;
        logic   last;
    } t_remap_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_idx;
    logic [KEY_W-1:0]     i_cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // ev_type[15:0], ev_code[31:16], ev_value[63:32], ev_stamp[127:64]
    logic [DATA_W-1:0]    s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    // out_type[15:0], out_code[31:16], out_value[63:32], out_stamp[127:64]
    logic [DATA_W-1:0]    m_axis_tdata;
    // click[0]
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    // Register copies and key tracking state of the remapper.
    logic [KEY_W-1:0] reg_phys_a, reg_phys_b, reg_virt_a, reg_virt_b;
    logic             held_a, held_b, active_a;

    t_remap_result remapped_q[$];
    int unsigned   mismatch_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   recv_hold_req = 0;
    int unsigned   recv_hold_left = 0;

    two_key_alternating_remapper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Key codes in use once zero registers fall back to their defaults.
    function automatic t_keys effective_keys();
        t_keys k;
        k.phys_a = (reg_phys_a != '0) ? reg_phys_a : KEY_Z;
        k.phys_b = (reg_phys_b != '0) ? reg_phys_b : KEY_X;
        k.virt_a = (reg_virt_a != '0) ? reg_virt_a : k.phys_a;
        k.virt_b = (reg_virt_b != '0) ? reg_virt_b : k.phys_b;
        return k;
    endfunction

    function automatic void push_remapped(input logic [TYPE_W-1:0] ev_type,
                                          input logic [CODE_W-1:0] ev_code,
                                          input logic [VALUE_W-1:0] ev_value,
                                          input logic [STAMP_W-1:0] ev_stamp,
                                          input logic click, input logic last);
        t_remap_result r;
        r.ev.ev_type  = ev_type;
        r.ev.ev_code  = ev_code;
        r.ev.ev_value = ev_value;
        r.ev.ev_stamp = ev_stamp;
        r.click = click;
        r.last  = last;
        remapped_q.push_back(r);
    endfunction

    // Works out the events that one accepted input beat gives.
    function automatic void remap_event(input t_event ev);
        t_keys            k;
        logic [CODE_W-1:0] oc;
        logic [VALUE_W-1:0] val;
        logic             is_a;
        int unsigned      level_sum;
        k   = effective_keys();
        val = ev.ev_value;
        // Scan events vanish; anything that is not one of the two keys passes.
        if (ev.ev_type == TYPE_MSC && ev.ev_code == CODE_SCAN)
            return;
        if (ev.ev_type != TYPE_KEY ||
            (ev.ev_code != CODE_W'(k.phys_a) && ev.ev_code != CODE_W'(k.phys_b))) begin
            push_remapped(ev.ev_type, ev.ev_code, val, ev.ev_stamp, 1'b0, 1'b1);
            return;
        end
        if (val == VAL_REPEAT)
            return;
        // Unknown key values pass through without touching the key levels.
        if (val > VAL_PRESS) begin
            push_remapped(ev.ev_type, ev.ev_code, val, ev.ev_stamp,
                          ev.ev_code != '0, 1'b1);
            return;
        end
        is_a = (ev.ev_code == CODE_W'(k.phys_a));
        if (is_a)
            held_a = (val == VAL_PRESS);
        else
            held_b = (val == VAL_PRESS);
        level_sum = int'(held_a) + int'(held_b) + int'(val[0]);
        if (level_sum == 2) begin
            // A lone press selects its own virtual key.
            active_a = is_a;
            oc = active_a ? CODE_W'(k.virt_a) : CODE_W'(k.virt_b);
            push_remapped(ev.ev_type, oc, val, ev.ev_stamp, oc != '0, 1'b1);
        end else if (level_sum == 0) begin
            // The final release goes to whichever virtual key was active.
            oc = active_a ? CODE_W'(k.virt_a) : CODE_W'(k.virt_b);
            active_a = 1'b0;
            push_remapped(ev.ev_type, oc, val, ev.ev_stamp, oc != '0, 1'b1);
        end else begin
            // Switch: release the active key, sync, then press the other one.
            oc = active_a ? CODE_W'(k.virt_a) : CODE_W'(k.virt_b);
            push_remapped(TYPE_KEY, oc, VAL_RELEASE, '0, 1'b0, 1'b0);
            push_remapped(TYPE_SYN, '0, '0, '0, 1'b0, 1'b0);
            oc = active_a ? CODE_W'(k.virt_b) : CODE_W'(k.virt_a);
            active_a = !active_a;
            push_remapped(ev.ev_type, oc, VAL_PRESS, ev.ev_stamp, oc != '0, 1'b1);
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (recv_hold_req != 0) begin
            recv_hold_left = recv_hold_req;
            recv_hold_req  = 0;
        end
        if (recv_hold_left != 0) begin
            recv_hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every output beat with the oldest predicted event.
    always @(posedge i_clk) begin : check_output
        t_event        got;
        t_remap_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (remapped_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %h", $time,
                         m_axis_tdata);
                mismatch_count++;
            end else begin
                want = remapped_q.pop_front();
                check_field("type", want.ev.ev_type, got.ev_type);
                check_field("code", want.ev.ev_code, got.ev_code);
                check_field("value", $unsigned(want.ev.ev_value), $unsigned(got.ev_value));
                check_field("stamp", want.ev.ev_stamp, got.ev_stamp);
                check_field("click", want.click, m_axis_tuser);
                check_field("last", want.last, m_axis_tlast);
            end
        end
    end

    // Offer one beat, with random idle cycles ahead of it, until it is taken.
    task automatic send_event(input t_event ev);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ev;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        remap_event(ev);
    endtask

    task automatic send_fields(input logic [TYPE_W-1:0] ev_type,
                               input logic [CODE_W-1:0] ev_code,
                               input logic [VALUE_W-1:0] ev_value,
                               input logic [STAMP_W-1:0] ev_stamp);
        t_event ev;
        ev.ev_type  = ev_type;
        ev.ev_code  = ev_code;
        ev.ev_value = ev_value;
        ev.ev_stamp = ev_stamp;
        send_event(ev);
    endtask

    task automatic send_key(input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] val);
        send_fields(TYPE_KEY, code, val, {$urandom, $urandom});
    endtask

    // Stop offering beats and let every predicted event come out.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (remapped_q.size() != 0)
            @(posedge i_clk);
        // Beats that give no event may still be in the pipeline.
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_key_reg(input logic [IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_PHYS_A: reg_phys_a = val;
            CFG_PHYS_B: reg_phys_b = val;
            CFG_VIRT_A: reg_virt_a = val;
            default:    reg_virt_b = val;
        endcase
    endtask

    task automatic set_keys(input logic [KEY_W-1:0] pa, input logic [KEY_W-1:0] pb,
                            input logic [KEY_W-1:0] va, input logic [KEY_W-1:0] vb);
        write_key_reg(CFG_PHYS_A, pa);
        write_key_reg(CFG_PHYS_B, pb);
        write_key_reg(CFG_VIRT_A, va);
        write_key_reg(CFG_VIRT_B, vb);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] random_key_code();
        if ($urandom_range(9) == 0)
            return '0;
        return KEY_W'($urandom_range(767, 1));
    endfunction

    // Mostly clean press/release traffic on the two keys, the rest noise.
    function automatic t_event random_event();
        t_event      ev;
        t_keys       k;
        int unsigned pick;
        int unsigned vpick;
        logic        level;
        k    = effective_keys();
        pick = $urandom_range(99);
        ev.ev_type  = TYPE_W'($urandom);
        ev.ev_code  = CODE_W'($urandom);
        ev.ev_value = $urandom;
        ev.ev_stamp = {$urandom, $urandom};
        if (pick < 70) begin
            ev.ev_type = TYPE_KEY;
            ev.ev_code = $urandom_range(1) ? CODE_W'(k.phys_a) : CODE_W'(k.phys_b);
            level = (ev.ev_code == CODE_W'(k.phys_a)) ? held_a : held_b;
            vpick = $urandom_range(99);
            if (vpick < 85)
                ev.ev_value = level ? VAL_RELEASE : VAL_PRESS;
            else if (vpick < 95)
                ev.ev_value = VAL_REPEAT;
        end else if (pick < 78) begin
            ev.ev_type = TYPE_MSC;
            ev.ev_code = CODE_SCAN;
        end else if (pick < 86) begin
            ev.ev_type  = TYPE_SYN;
            ev.ev_code  = '0;
            ev.ev_value = '0;
        end else if (pick >= 93) begin
            ev.ev_type = TYPE_KEY;
        end
        return ev;
    endfunction

    // Default keys: every mapping case, the filters and field extremes.
    task automatic test_directed_events();
        send_key(CODE_W'(KEY_Z), VAL_PRESS);
        send_key(CODE_W'(KEY_Z), VAL_REPEAT);
        send_key(CODE_W'(KEY_X), VAL_PRESS);
        send_key(CODE_W'(KEY_X), VAL_REPEAT);
        send_key(CODE_W'(KEY_Z), VAL_RELEASE);
        send_key(CODE_W'(KEY_X), VAL_RELEASE);
        send_fields(TYPE_MSC, CODE_SCAN, 32'h1234_5678, '1);
        send_fields(TYPE_MSC, 16'd3, 32'd7, 64'h1);
        send_fields(TYPE_SYN, '0, '0, '0);
        send_fields('1, '1, 32'h7FFF_FFFF, '1);
        send_key(CODE_W'(KEY_Z), 32'hFFFF_FFFF);
        send_key(CODE_W'(KEY_X), 32'd3);
        send_key(CODE_W'(KEY_X), 32'h8000_0000);
        send_key('0, VAL_PRESS);
        send_key('1, VAL_RELEASE);
        send_key(CODE_W'(KEY_X), VAL_RELEASE);
        send_key(CODE_W'(KEY_X), VAL_PRESS);
        send_key(CODE_W'(KEY_Z), VAL_PRESS);
        send_key(CODE_W'(KEY_X), VAL_RELEASE);
        send_key(CODE_W'(KEY_Z), VAL_RELEASE);
        wait_idle();
    endtask

    // Zero registers fall back to the default physical codes.
    task automatic test_zero_registers();
        set_keys('0, '0, '0, '0);
        send_key(CODE_W'(KEY_Z), VAL_PRESS);
        send_key(CODE_W'(KEY_X), VAL_PRESS);
        send_key(CODE_W'(KEY_X), VAL_RELEASE);
        send_key(CODE_W'(KEY_Z), VAL_RELEASE);
        wait_idle();
    endtask

    // Both physical keys on one code: the code counts as the first key.
    task automatic test_equal_phys_keys();
        set_keys(10'd100, 10'd100, 10'd767, 10'd0);
        send_key(16'd100, VAL_PRESS);
        send_key(16'd100, VAL_PRESS);
        send_key(16'd100, VAL_REPEAT);
        send_key(16'd100, VAL_RELEASE);
        send_key(CODE_W'(KEY_Z), VAL_PRESS);
        wait_idle();
    endtask

    // Smallest nonzero code 1 and code 767, swapped between the two sides.
    task automatic test_extreme_key_codes();
        set_keys(10'd767, 10'd1, 10'd1, 10'd767);
        send_key(16'd1, VAL_PRESS);
        send_key(16'd767, VAL_PRESS);
        send_key(16'd1, VAL_RELEASE);
        send_key(16'd767, VAL_REPEAT);
        send_key(16'd767, VAL_RELEASE);
        send_key(16'd1791, VAL_PRESS);
        wait_idle();
    endtask

    // Random traffic under each idling mix, with new key codes twice per mix.
    task automatic test_random_traffic();
        int unsigned send_mix[4] = '{0, 48, 0, 19};
        int unsigned recv_mix[4] = '{0, 0, 48, 19};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_mix[p];
            recv_stall_pct = recv_mix[p];
            for (int c = 0; c < 2; c++) begin
                set_keys(random_key_code(), random_key_code(),
                         random_key_code(), random_key_code());
                for (int n = 0; n < 36; n++)
                    send_event(random_event());
                wait_idle();
            end
        end
    endtask

    // Long output hold-off while beats keep coming, so the input stalls.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_keys(KEY_Z, KEY_X, KEY_F13, KEY_F14);
        recv_hold_req = 200;
        for (int n = 0; n < 30; n++)
            send_event(random_event());
        wait_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PHYS_A;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        reg_phys_a = KEY_Z;
        reg_phys_b = KEY_X;
        reg_virt_a = KEY_F13;
        reg_virt_b = KEY_F14;
        held_a   = 1'b0;
        held_b   = 1'b0;
        active_a = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_events();
        test_zero_registers();
        test_equal_phys_keys();
        test_extreme_key_codes();
        test_random_traffic();
        test_output_backpressure();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && remapped_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(2_000_000);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
